### src/drrs_pkg.sv
// Shared constants, codes and types for the dirty region refresh selector.
// No dependencies; used by every module of the block.
package drrs_pkg;

   localparam int FRAME_WIDTH   = 256;
   localparam int FRAME_HEIGHT  = 128;
   localparam int BYTES_PER_ROW = 32;
   localparam int FRAME_SIZE    = FRAME_HEIGHT * BYTES_PER_ROW;

   localparam int PIXEL_W  = 8;
   localparam int SCREEN_W = 5;
   localparam int KIND_W   = 2;
   localparam int WINX_W   = 8;
   localparam int WINY_W   = 7;
   localparam int WINW_W   = 9;
   localparam int WINH_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int THR_W    = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int POS_W   = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
   localparam int ROW_W   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
   localparam int COL_W   = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int SPANR_W = $clog2(FRAME_HEIGHT + 1);
   localparam int SPANC_W = $clog2(BYTES_PER_ROW + 1);
   localparam int LEFT_W  = $clog2(FRAME_WIDTH + 1);
   localparam int PROD_W  = SPANC_W + SPANR_W;

   // dirty area * 100 with area = byte columns * 8 * rows
   localparam int AREA_SCALE = 8 * 100;
   localparam int LHS_W      = PROD_W + $clog2(AREA_SCALE + 1);
   localparam int RHS_W      = THR_W + $clog2(FRAME_WIDTH * FRAME_HEIGHT + 1);
   localparam int CMP_W      = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT     = 2'd1;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 7'd75;
   localparam logic [COUNT_W-1:0] LIMIT_RESET     = 8'd30;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic                dirty;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic                last;
      logic [SCREEN_W-1:0] screen_id;
      logic                force_full;
   } q_entry_type;

endpackage

### src/drrs_front.sv
// Front end: byte position counter, previous-frame store and change detection.
// Depends on drrs_pkg; pushes one classified entry per accepted request.
module drrs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [drrs_pkg::PIXEL_W-1:0]  req_pixel_byte,
   input  logic [drrs_pkg::SCREEN_W-1:0] req_screen_id,
   input  logic                          req_force_full,
   input  logic [drrs_pkg::QCNT_W-1:0]   q_count,
   output logic                          q_push,
   output drrs_pkg::q_entry_type         q_entry
);
   import drrs_pkg::*;

   logic [PIXEL_W-1:0]  frame_ff [FRAME_SIZE];
   logic [PIXEL_W-1:0]  rd_data_ff;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                wrapped_ff, wrapped_in;
   logic                s1_valid_ff;
   logic [PIXEL_W-1:0]  s1_px_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_last_ff;
   logic                s1_seen_ff;
   logic [SCREEN_W-1:0] s1_screen_ff;
   logic                s1_force_ff;

   logic                accept;
   logic                at_last;
   logic [PIXEL_W-1:0]  prev_px;
   logic [QCNT_W:0]     in_flight;

   assign in_flight = {1'b0, q_count} + (QCNT_W+1)'(s1_valid_ff);
   assign req_stall = (in_flight >= (QCNT_W+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign at_last   = (pos_ff == POS_W'(FRAME_SIZE - 1));

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (at_last) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         wrapped_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         wrapped_ff  <= wrapped_in;
         s1_valid_ff <= accept;
      end
   end

   // read-before-write of the same entry
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff[pos_ff] <= req_pixel_byte;
         rd_data_ff       <= frame_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= req_pixel_byte;
         s1_row_ff    <= ROW_W'(pos_ff / BYTES_PER_ROW);
         s1_col_ff    <= COL_W'(pos_ff % BYTES_PER_ROW);
         s1_last_ff   <= at_last;
         s1_seen_ff   <= wrapped_ff;
         s1_screen_ff <= req_screen_id;
         s1_force_ff  <= req_force_full;
      end
   end

   // entries not yet written since reset read as zero
   assign prev_px = s1_seen_ff ? rd_data_ff : '0;

   assign q_push = s1_valid_ff;
   always_comb begin
      q_entry.dirty      = (s1_px_ff != prev_px);
      q_entry.row        = s1_row_ff;
      q_entry.col        = s1_col_ff;
      q_entry.last       = s1_last_ff;
      q_entry.screen_id  = s1_screen_ff;
      q_entry.force_full = s1_force_ff;
   end

endmodule

### src/drrs_queue.sv
// Short FIFO of classified entries between front end and decision back end.
// Depends on drrs_pkg for the entry type and depth.
module drrs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  drrs_pkg::q_entry_type       push_entry,
   input  logic                        pop,
   output logic                        not_empty,
   output drrs_pkg::q_entry_type       head,
   output logic [drrs_pkg::QCNT_W-1:0] count
);
   import drrs_pkg::*;

   q_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### src/drrs_back.sv
// Back end: bounding box tracking, refresh decision, partial counter,
// configuration registers and response register. Depends on drrs_pkg.
module drrs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_not_empty,
   input  drrs_pkg::q_entry_type            q_head,
   output logic                             q_pop,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [drrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [drrs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [drrs_pkg::KIND_W-1:0]      rsp_refresh_kind,
   output logic [drrs_pkg::WINX_W-1:0]      rsp_win_x,
   output logic [drrs_pkg::WINY_W-1:0]      rsp_win_y,
   output logic [drrs_pkg::WINW_W-1:0]      rsp_win_width,
   output logic [drrs_pkg::WINH_W-1:0]      rsp_win_height,
   output logic [drrs_pkg::COUNT_W-1:0]     rsp_partial_count_now
);
   import drrs_pkg::*;

   logic [THR_W-1:0]    thr_ff;
   logic [COUNT_W-1:0]  limit_ff;

   logic [ROW_W-1:0]    min_row_ff, max_row_ff, min_row_in, max_row_in;
   logic [COL_W-1:0]    min_col_ff, max_col_ff, min_col_in, max_col_in;
   logic                any_ff, any_in;

   logic                d_valid_ff;
   logic                d_any_ff;
   logic [ROW_W-1:0]    d_min_row_ff;
   logic [COL_W-1:0]    d_min_col_ff;
   logic [SPANR_W-1:0]  d_span_row_ff;
   logic [SPANC_W-1:0]  d_span_col_ff;
   logic [SCREEN_W-1:0] d_screen_ff;
   logic                d_force_ff;

   logic [COUNT_W-1:0]  partial_ff, partial_in;
   logic [SCREEN_W-1:0] last_screen_ff;

   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [WINX_W-1:0]   win_x_ff, win_x_in;
   logic [WINY_W-1:0]   win_y_ff, win_y_in;
   logic [WINW_W-1:0]   win_w_ff, win_w_in;
   logic [WINH_W-1:0]   win_h_ff, win_h_in;

   logic                out_free, d_free, d_fire, last_pop;
   logic [ROW_W-1:0]    nx_min_row, nx_max_row;
   logic [COL_W-1:0]    nx_min_col, nx_max_col;
   logic                nx_any;
   logic [PROD_W-1:0]   prod;
   logic [CMP_W-1:0]    lhs, rhs;
   logic [LEFT_W-1:0]   left, wpix, fw;
   logic [LEFT_W:0]     right;
   logic                go_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff   <= csr_wdata[THR_W-1:0];
            CSR_LIMIT:     limit_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign d_fire   = d_valid_ff && out_free;
   assign d_free   = !d_valid_ff || out_free;
   assign q_pop    = q_not_empty && (!q_head.last || d_free);
   assign last_pop = q_pop && q_head.last;

   // box including the popped byte
   always_comb begin
      nx_min_row = min_row_ff;
      nx_max_row = max_row_ff;
      nx_min_col = min_col_ff;
      nx_max_col = max_col_ff;
      nx_any     = any_ff;
      if (q_head.dirty) begin
         nx_any = 1'b1;
         if (!any_ff) begin
            nx_min_row = q_head.row;
            nx_max_row = q_head.row;
            nx_min_col = q_head.col;
            nx_max_col = q_head.col;
         end else begin
            if (q_head.row < min_row_ff) nx_min_row = q_head.row;
            if (q_head.row > max_row_ff) nx_max_row = q_head.row;
            if (q_head.col < min_col_ff) nx_min_col = q_head.col;
            if (q_head.col > max_col_ff) nx_max_col = q_head.col;
         end
      end
   end

   always_comb begin
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      any_in     = any_ff;
      if (q_pop) begin
         if (q_head.last) begin
            min_row_in = '1;
            max_row_in = '0;
            min_col_in = '1;
            max_col_in = '0;
            any_in     = 1'b0;
         end else begin
            min_row_in = nx_min_row;
            max_row_in = nx_max_row;
            min_col_in = nx_min_col;
            max_col_in = nx_max_col;
            any_in     = nx_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_row_ff <= '1;
         max_row_ff <= '0;
         min_col_ff <= '1;
         max_col_ff <= '0;
         any_ff     <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         any_ff     <= any_in;
         d_valid_ff <= last_pop || (d_valid_ff && !out_free);
      end
   end

   always_ff @(posedge clock) begin
      if (last_pop) begin
         d_any_ff      <= nx_any;
         d_min_row_ff  <= nx_min_row;
         d_min_col_ff  <= nx_min_col;
         d_span_row_ff <= SPANR_W'(nx_max_row) - SPANR_W'(nx_min_row) + SPANR_W'(1);
         d_span_col_ff <= SPANC_W'(nx_max_col) - SPANC_W'(nx_min_col) + SPANC_W'(1);
         d_screen_ff   <= q_head.screen_id;
         d_force_ff    <= q_head.force_full;
      end
   end

   always_comb begin
      prod    = PROD_W'(d_span_col_ff) * PROD_W'(d_span_row_ff);
      lhs     = CMP_W'(prod) * CMP_W'(AREA_SCALE);
      rhs     = CMP_W'(thr_ff) * CMP_W'(FRAME_WIDTH * FRAME_HEIGHT);
      go_full = d_force_ff || (d_screen_ff != last_screen_ff) || (lhs > rhs) ||
                (partial_ff >= limit_ff);
      fw      = LEFT_W'(FRAME_WIDTH);
      left    = LEFT_W'(d_min_col_ff) << 3;
      wpix    = LEFT_W'(d_span_col_ff) << 3;
      right   = {1'b0, left} + {1'b0, wpix};

      kind_in    = KIND_NONE;
      win_x_in   = '0;
      win_y_in   = '0;
      win_w_in   = '0;
      win_h_in   = '0;
      partial_in = partial_ff;
      if (d_any_ff) begin
         if (go_full) begin
            kind_in    = KIND_FULL;
            win_w_in   = WINW_W'(FRAME_WIDTH);
            win_h_in   = WINH_W'(FRAME_HEIGHT);
            partial_in = '0;
         end else begin
            kind_in  = KIND_PARTIAL;
            win_x_in = WINX_W'(left);
            win_y_in = WINY_W'(d_min_row_ff);
            win_h_in = WINH_W'(d_span_row_ff);
            if (left >= fw) begin
               win_w_in = '0;
            end else if (right > {1'b0, fw}) begin
               win_w_in = WINW_W'(fw - left);
            end else begin
               win_w_in = WINW_W'(wpix);
            end
            if (partial_ff != COUNT_MAX) begin
               partial_in = partial_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff     <= '0;
         last_screen_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (d_fire) begin
            partial_ff     <= partial_in;
            last_screen_ff <= d_screen_ff;
         end
         rsp_valid_ff <= d_fire || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (d_fire) begin
         kind_ff  <= kind_in;
         win_x_ff <= win_x_in;
         win_y_ff <= win_y_in;
         win_w_ff <= win_w_in;
         win_h_ff <= win_h_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_refresh_kind      = kind_ff;
   assign rsp_win_x             = win_x_ff;
   assign rsp_win_y             = win_y_ff;
   assign rsp_win_width         = win_w_ff;
   assign rsp_win_height        = win_h_ff;
   assign rsp_partial_count_now = partial_ff;

`ifndef ASSERT_OFF
   a_full_clears_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == KIND_FULL) |-> (partial_ff == '0))
      else $error("full refresh left partial count nonzero");

   a_none_empty_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == KIND_NONE) |-> (win_w_ff == '0) && (win_h_ff == '0))
      else $error("no-refresh result carries a window");

   a_decision_held: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && !out_free |=> d_valid_ff && $stable(d_screen_ff))
      else $error("pending decision lost while response stalled");

   a_box_cleared: assert property (@(posedge clock) disable iff (reset)
      last_pop |=> !any_ff)
      else $error("bounding box not cleared at end of frame");
`endif

endmodule

### src/dirty_region_refresh_select.sv
// Top level of the dirty region refresh selector.
// Depends on drrs_pkg, drrs_front, drrs_queue and drrs_back.
//
// Accepts one frame byte per cycle while req_stall is low, in raster order; the
// byte position is counted internally (128 rows of 32 bytes). Each byte is read
// from and written to the previous-frame store in the cycle it is taken and
// compared in the next cycle, so the store's single read-write access sets the
// rate of one byte per clock. Until the first frame after reset completes, stored
// bytes read as zero (a wrap flag stands in for a clearing pass, so there is
// none). Only a frame's last byte gives a result, registered on rsp after the
// compare stage, queue and decision register; rsp_stall can delay it.
// A four-entry queue between the compare front end and the decision back end
// lets requests keep flowing while a result waits on rsp_stall.
module dirty_region_refresh_select (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [drrs_pkg::PIXEL_W-1:0]     req_pixel_byte,
   input  logic [drrs_pkg::SCREEN_W-1:0]    req_screen_id,
   input  logic                             req_force_full,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [drrs_pkg::KIND_W-1:0]      rsp_refresh_kind,
   output logic [drrs_pkg::WINX_W-1:0]      rsp_win_x,
   output logic [drrs_pkg::WINY_W-1:0]      rsp_win_y,
   output logic [drrs_pkg::WINW_W-1:0]      rsp_win_width,
   output logic [drrs_pkg::WINH_W-1:0]      rsp_win_height,
   output logic [drrs_pkg::COUNT_W-1:0]     rsp_partial_count_now,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [drrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [drrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import drrs_pkg::*;

   logic              q_push, q_pop, q_not_empty;
   q_entry_type       q_in, q_head;
   logic [QCNT_W-1:0] q_count;

   drrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .req_screen_id  (req_screen_id),
      .req_force_full (req_force_full),
      .q_count        (q_count),
      .q_push         (q_push),
      .q_entry        (q_in)
   );

   drrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head),
      .count      (q_count)
   );

   drrs_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_not_empty           (q_not_empty),
      .q_head                (q_head),
      .q_pop                 (q_pop),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_refresh_kind      (rsp_refresh_kind),
      .rsp_win_x             (rsp_win_x),
      .rsp_win_y             (rsp_win_y),
      .rsp_win_width         (rsp_win_width),
      .rsp_win_height        (rsp_win_height),
      .rsp_partial_count_now (rsp_partial_count_now)
   );

endmodule

### test/dirty_region_refresh_select_test.sv
// Self-checking testbench for dirty_region_refresh_select: streams whole frames byte by byte,
// predicts every refresh decision with a behavioral model and compares each result.
// Depends on drrs_pkg and the block's RTL.
module dirty_region_refresh_select_test;
   timeunit 1ns;
   timeprecision 1ps;
   import drrs_pkg::*;

   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int HOLD_CYCLES      = 20_000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int RANDOM_PHASES    = 8;
   localparam int FRAMES_PER_PHASE = 4;

   typedef struct {
      logic [PIXEL_W-1:0]  pixel;
      logic [SCREEN_W-1:0] screen_id;
      logic                force_full;
      bit                  drain_first;
   } frame_byte_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WINX_W-1:0]  x;
      logic [WINY_W-1:0]  y;
      logic [WINW_W-1:0]  width;
      logic [WINH_W-1:0]  height;
      logic [COUNT_W-1:0] count;
   } refresh_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_byte = '0;
   logic [SCREEN_W-1:0]    req_screen_id = '0;
   logic                   req_force_full = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_W-1:0]      rsp_refresh_kind;
   logic [WINX_W-1:0]      rsp_win_x;
   logic [WINY_W-1:0]      rsp_win_y;
   logic [WINW_W-1:0]      rsp_win_width;
   logic [WINH_W-1:0]      rsp_win_height;
   logic [COUNT_W-1:0]     rsp_partial_count_now;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   frame_byte_type byte_queue [$];
   refresh_type    pending_refreshes [$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_count = 0;

   // model of the block
   logic [PIXEL_W-1:0]  frame_store [FRAME_SIZE];
   int unsigned         scan_pos;
   logic [ROW_W-1:0]    top_row, bottom_row;
   logic [COL_W-1:0]    left_col, right_col;
   logic                box_valid;
   logic [COUNT_W-1:0]  partial_run;
   logic [SCREEN_W-1:0] shown_screen;
   logic [THR_W-1:0]    area_threshold;
   logic [COUNT_W-1:0]  partial_limit;

   // frame generator
   logic [PIXEL_W-1:0]  sent_image [FRAME_SIZE];
   logic [PIXEL_W-1:0]  next_image [FRAME_SIZE];
   logic [SCREEN_W-1:0] gen_screen;

   dirty_region_refresh_select i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pixel_byte        (req_pixel_byte),
      .req_screen_id         (req_screen_id),
      .req_force_full        (req_force_full),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_refresh_kind      (rsp_refresh_kind),
      .rsp_win_x             (rsp_win_x),
      .rsp_win_y             (rsp_win_y),
      .rsp_win_width         (rsp_win_width),
      .rsp_win_height        (rsp_win_height),
      .rsp_partial_count_now (rsp_partial_count_now),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_box;
      top_row    = '1;
      bottom_row = '0;
      left_col   = '1;
      right_col  = '0;
      box_valid  = 1'b0;
   endtask

   task automatic predict_refresh(input logic [PIXEL_W-1:0] pixel,
                                  input logic [SCREEN_W-1:0] screen_id,
                                  input logic force_full);
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      longint unsigned  span_w, span_h, left, width;
      bit               go_full;
      refresh_type      r;
      row = ROW_W'(scan_pos / BYTES_PER_ROW);
      col = COL_W'(scan_pos % BYTES_PER_ROW);
      if (pixel != frame_store[scan_pos]) begin
         if (!box_valid) begin
            top_row    = row;
            bottom_row = row;
            left_col   = col;
            right_col  = col;
            box_valid  = 1'b1;
         end else begin
            if (row < top_row) top_row = row;
            if (row > bottom_row) bottom_row = row;
            if (col < left_col) left_col = col;
            if (col > right_col) right_col = col;
         end
      end
      frame_store[scan_pos] = pixel;
      if (scan_pos + 1 < FRAME_SIZE) begin
         scan_pos++;
         return;
      end
      r = '0;
      r.kind = KIND_NONE;
      go_full = force_full || (screen_id != shown_screen);
      shown_screen = screen_id;
      if (box_valid) begin
         span_w = (64'(right_col) - 64'(left_col) + 1) * 8;
         span_h = 64'(bottom_row) - 64'(top_row) + 1;
         if (span_w * span_h * 100 > 64'(area_threshold) * FRAME_WIDTH * FRAME_HEIGHT)
            go_full = 1'b1;
         if (partial_run >= partial_limit) go_full = 1'b1;
         if (go_full) begin
            r.kind      = KIND_FULL;
            r.width     = WINW_W'(FRAME_WIDTH);
            r.height    = WINH_W'(FRAME_HEIGHT);
            partial_run = '0;
         end else begin
            left  = 64'(left_col) * 8;
            width = span_w;
            if (left >= FRAME_WIDTH) width = 0;
            else if (left + width > FRAME_WIDTH) width = FRAME_WIDTH - left;
            r.kind   = KIND_PARTIAL;
            r.x      = left[WINX_W-1:0];
            r.y      = top_row;
            r.width  = width[WINW_W-1:0];
            r.height = span_h[WINH_W-1:0];
            if (partial_run != COUNT_MAX) partial_run++;
         end
      end
      r.count = partial_run;
      pending_refreshes.insert(pending_refreshes.size(), r);
      scan_pos = 0;
      clear_box();
   endtask

   // driver: one request per cycle at most, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_refresh(req_pixel_byte, req_screen_id, req_force_full);
            void'(byte_queue.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() > 0 &&
                !(byte_queue[0].drain_first && pending_refreshes.size() > 0) &&
                $urandom_range(99) >= sender_idle_pct) begin
               req_valid      <= 1'b1;
               req_pixel_byte <= byte_queue[0].pixel;
               req_screen_id  <= byte_queue[0].screen_id;
               req_force_full <= byte_queue[0].force_full;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      refresh_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_refreshes.size() == 0) begin
            $error("refresh result with none expected");
            error_count++;
         end else begin
            want = pending_refreshes.pop_front();
            check_field("refresh_kind", 16'(want.kind), 16'(rsp_refresh_kind));
            check_field("win_x", 16'(want.x), 16'(rsp_win_x));
            check_field("win_y", 16'(want.y), 16'(rsp_win_y));
            check_field("win_width", 16'(want.width), 16'(rsp_win_width));
            check_field("win_height", 16'(want.height), 16'(rsp_win_height));
            check_field("partial_count_now", 16'(want.count),
                        16'(rsp_partial_count_now));
         end
      end
      rsp_stall <= (hold_go && !hold_done) || ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic write_config(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_THRESHOLD) area_threshold = value[THR_W-1:0];
      else if (index == CSR_LIMIT) partial_limit = value;
   endtask

   task automatic wait_idle;
      while (byte_queue.size() != 0 || pending_refreshes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic begin_frame;
      foreach (sent_image[i]) next_image[i] = sent_image[i];
   endtask

   task automatic invert_rect(input int r0, input int r1, input int c0, input int c1);
      for (int r = r0; r <= r1; r++)
         for (int c = c0; c <= c1; c++)
            next_image[r * BYTES_PER_ROW + c] = ~next_image[r * BYTES_PER_ROW + c];
   endtask

   task automatic scramble_rect(input int r0, input int r1, input int c0, input int c1);
      for (int r = r0; r <= r1; r++)
         for (int c = c0; c <= c1; c++)
            if ($urandom_range(1))
               next_image[r * BYTES_PER_ROW + c] = PIXEL_W'($urandom_range(255));
   endtask

   task automatic send_frame(input logic [SCREEN_W-1:0] screen_id, input logic force_full,
                             input bit drain_first);
      frame_byte_type b;
      for (int p = 0; p < FRAME_SIZE; p++) begin
         b.pixel       = next_image[p];
         b.screen_id   = (p == FRAME_SIZE - 1) ? screen_id : SCREEN_W'($urandom);
         b.force_full  = (p == FRAME_SIZE - 1) ? force_full : 1'($urandom);
         b.drain_first = drain_first && p == 0;
         byte_queue.insert(byte_queue.size(), b);
         sent_image[p] = next_image[p];
      end
      gen_screen = screen_id;
   endtask

   task automatic random_frame(input bit drain_first);
      int                  pick, r0, c0, rows, cols, hits;
      logic [SCREEN_W-1:0] screen_id;
      begin_frame();
      pick = $urandom_range(99);
      if (pick < 45) begin
         rows = $urandom_range(8, 1);
         cols = $urandom_range(4, 1);
         r0 = $urandom_range(FRAME_HEIGHT - rows);
         c0 = $urandom_range(BYTES_PER_ROW - cols);
         scramble_rect(r0, r0 + rows - 1, c0, c0 + cols - 1);
      end else if (pick < 60) begin
         hits = $urandom_range(6, 1);
         for (int k = 0; k < hits; k++) begin
            r0 = $urandom_range(FRAME_HEIGHT - 1);
            c0 = $urandom_range(BYTES_PER_ROW - 1);
            next_image[r0 * BYTES_PER_ROW + c0] ^= PIXEL_W'($urandom_range(255, 1));
         end
      end else if (pick < 75) begin
         rows = $urandom_range(FRAME_HEIGHT, 1);
         cols = $urandom_range(BYTES_PER_ROW, 1);
         r0 = $urandom_range(FRAME_HEIGHT - rows);
         c0 = $urandom_range(BYTES_PER_ROW - cols);
         scramble_rect(r0, r0 + rows - 1, c0, c0 + cols - 1);
      end else if (pick < 85) begin
         scramble_rect(0, FRAME_HEIGHT - 1, 0, BYTES_PER_ROW - 1);
      end
      screen_id = ($urandom_range(99) < 15) ? SCREEN_W'($urandom) : gen_screen;
      send_frame(screen_id, $urandom_range(99) < 8, drain_first);
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int thr, lim;
      foreach (frame_store[i]) frame_store[i] = '0;
      foreach (sent_image[i]) sent_image[i] = '0;
      scan_pos       = 0;
      partial_run    = '0;
      shown_screen   = '0;
      area_threshold = THRESHOLD_RESET;
      partial_limit  = LIMIT_RESET;
      gen_screen     = '0;
      clear_box();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unchanged frames, forced with nothing changed, edge bytes
      begin_frame();
      send_frame(5'd0, 1'b0, 1'b0);
      begin_frame();
      send_frame(5'd0, 1'b1, 1'b0);
      begin_frame();
      invert_rect(5, 5, 3, 3);
      send_frame(5'd0, 1'b0, 1'b0);
      begin_frame();
      invert_rect(0, 0, BYTES_PER_ROW - 1, BYTES_PER_ROW - 1);
      send_frame(5'd0, 1'b0, 1'b0);
      begin_frame();
      invert_rect(FRAME_HEIGHT - 1, FRAME_HEIGHT - 1, 0, 0);
      send_frame(5'd0, 1'b0, 1'b0);
      begin_frame();
      invert_rect(FRAME_HEIGHT - 1, FRAME_HEIGHT - 1, BYTES_PER_ROW - 1, BYTES_PER_ROW - 1);
      send_frame(5'd0, 1'b1, 1'b0);
      begin_frame();
      invert_rect(60, 60, 10, 10);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      invert_rect(0, FRAME_HEIGHT - 1, 0, BYTES_PER_ROW - 1);
      send_frame(5'd31, 1'b0, 1'b0);
      // bounding box exactly at 75 percent, then one column past it
      begin_frame();
      invert_rect(0, 0, 0, 0);
      invert_rect(FRAME_HEIGHT - 1, FRAME_HEIGHT - 1, 23, 23);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      invert_rect(0, 0, 0, 0);
      invert_rect(FRAME_HEIGHT - 1, FRAME_HEIGHT - 1, 24, 24);
      send_frame(5'd31, 1'b0, 1'b0);

      wait_idle();
      write_config(CSR_THRESHOLD, 8'd127);
      write_config(CSR_LIMIT, 8'd0);
      begin_frame();
      invert_rect(64, 64, 16, 16);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      send_frame(5'd31, 1'b0, 1'b0);

      wait_idle();
      write_config(CSR_THRESHOLD, 8'd100);
      write_config(CSR_LIMIT, 8'd255);
      begin_frame();
      invert_rect(0, FRAME_HEIGHT - 1, 0, BYTES_PER_ROW - 1);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      invert_rect(0, FRAME_HEIGHT - 1, 0, BYTES_PER_ROW - 1);
      send_frame(5'd31, 1'b0, 1'b0);

      wait_idle();
      write_config(CSR_THRESHOLD, 8'd0);
      begin_frame();
      invert_rect(1, 1, 1, 1);
      send_frame(5'd31, 1'b0, 1'b0);

      wait_idle();
      write_config(CSR_THRESHOLD, 8'd75);
      write_config(CSR_LIMIT, 8'd2);
      begin_frame();
      invert_rect(10, 12, 5, 6);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      invert_rect(100, 100, 30, 31);
      send_frame(5'd31, 1'b0, 1'b0);
      begin_frame();
      invert_rect(20, 20, 20, 20);
      send_frame(5'd31, 1'b0, 1'b0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         case ($urandom_range(4))
            0: thr = 0;
            1: thr = 100;
            2: thr = 127;
            default: thr = $urandom_range(100);
         endcase
         case ($urandom_range(3))
            0: lim = 0;
            1: lim = 255;
            default: lim = $urandom_range(8);
         endcase
         write_config(CSR_THRESHOLD, CSR_DATA_W'(thr));
         write_config(CSR_LIMIT, CSR_DATA_W'(lim));
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 48;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 48;
            end
            default: begin
               sender_idle_pct = 15;
               receiver_stall_pct = 15;
            end
         endcase
         for (int f = 0; f < FRAMES_PER_PHASE; f++)
            random_frame((ph == 0 && f == 2) || $urandom_range(9) == 0);
      end

      // receiver holds off while frames keep coming, so the input backs up
      wait_idle();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_go = 1'b1;
      for (int f = 0; f < 4; f++) random_frame(1'b0);
      wait (hold_done);
      wait_idle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
